// ----- rtl/fcml_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcml_pkg
// constants for the intermittency-map led flicker generator
// ----------------------------------------------------------------------------
package fcml_pkg;

	// number of led channels held in the level store
	localparam int NUM_CHANNELS = 8;
	localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// field widths
	localparam int CH_W    = 3;
	localparam int DRAW_W  = 16;
	localparam int LEVEL_W = 16;
	localparam int DUTY_W  = 8;

	// q0.16 thresholds
	localparam logic [LEVEL_W:0] LOW_LIMIT  = 17'd5243;
	localparam logic [LEVEL_W:0] HIGH_LIMIT = 17'd65208;
	localparam logic [LEVEL_W:0] LEVEL_MAX  = 17'd65535;

	// reseed numerators: base + ((draw * span) >> 16)
	localparam logic [7:0] LOW_BASE  = 8'd20;
	localparam logic [7:0] LOW_SPAN  = 8'd60;
	localparam logic [7:0] HIGH_BASE = 8'd128;
	localparam logic [7:0] HIGH_SPAN = 8'd125;

	// reseed divisor and duty scale
	localparam logic [10:0] RESEED_DIV = 11'd1023;
	localparam logic [7:0]  DUTY_SCALE = 8'd255;

endpackage

// ----- rtl/flicker_chaos_map_led_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flicker_chaos_map_led_top
// 1/f flicker generator for a bank of led channels
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries a channel index and a 16-bit
//   random draw. each transaction advances that channel's q0.16 level once
//   through the intermittency map and produces exactly one output
//   transaction (out_valid/out_ready) with the channel and its new 8-bit duty.
// path: the item is captured in the input register when it is accepted,
//   and the result register loads from it once the result register is
//   free; out_valid is the result register's valid flag.
// throughput: one transaction per cycle while out_ready stays high, set by
//   the combinational map logic (one 16x16 square, compares, a constant
//   reseed divider) between the input register and the result register;
//   the store write for a channel lands on the same edge as its result, so
//   back-to-back hits on one channel see the fresh level.
// stall: when out_ready is low the result register holds, the input register
//   holds one more item, and in_ready drops only once both are full.
// reset: arst_n clears all valid flags and all channel levels to zero.
//   a channel index at or above the channel count leaves the store alone
//   and returns duty zero.
// ----------------------------------------------------------------------------
module flicker_chaos_map_led_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fcml_pkg::CH_W-1:0]   channel,
	input  logic [fcml_pkg::DRAW_W-1:0] random_draw,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [fcml_pkg::CH_W-1:0]   channel_out,
	output logic [fcml_pkg::DUTY_W-1:0] duty
);
	import fcml_pkg::*;

	// (n << 16) / 1023 for n below 256: 65536 = 64*1023 + 64, so the
	// quotient is 64n + floor(64n / 1023), and that small term needs one
	// estimate by a shift and a single correction
	function automatic logic [LEVEL_W-1:0] reseed_level(input logic [7:0] n);
		logic [13:0] x;
		logic [3:0]  r;
		logic [10:0] rem;
		logic [4:0]  r_adj;
		x   = {n, 6'b0};
		r   = x[13:10];
		rem = {1'b0, x[9:0]} + {7'b0, r};
		r_adj = (rem >= RESEED_DIV) ? ({1'b0, r} + 5'd1) : {1'b0, r};
		reseed_level = {2'b0, x} + {11'b0, r_adj};
	endfunction

	// input register
	logic                    valid_s1;
	logic [CH_W-1:0]         channel_s1;
	logic [DRAW_W-1:0]       draw_s1;

	// result register
	logic                    out_valid_q;
	logic [CH_W-1:0]         channel_q;
	logic [DUTY_W-1:0]       duty_q;

	// per-channel level store
	logic [LEVEL_W-1:0]      level_q [NUM_CHANNELS];

	logic                    advance;
	logic [CH_IDX_W-1:0]     idx;
	logic                    in_range;
	logic [LEVEL_W-1:0]      level_cur;
	logic [LEVEL_W:0]        to_one;
	logic [LEVEL_W-1:0]      sq_op;
	logic [2*LEVEL_W-1:0]    sq;
	logic [LEVEL_W:0]        delta;
	logic [LEVEL_W:0]        t_up;
	logic [LEVEL_W:0]        t_map;
	logic [DRAW_W+7:0]       low_prod;
	logic [DRAW_W+7:0]       high_prod;
	logic [7:0]              low_n;
	logic [7:0]              high_n;
	logic [LEVEL_W-1:0]      level_new;
	logic [LEVEL_W+DUTY_W-1:0] duty_prod;
	logic [DUTY_W-1:0]       duty_new;

	// result register frees when empty or taken this cycle
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	assign idx       = CH_IDX_W'(channel_s1);
	assign in_range  = (32'(channel_s1) < NUM_CHANNELS);
	assign level_cur = level_q[idx];

	// one shared square: the level itself below one half, else its
	// distance to one (at most one half, so 16 bits hold it)
	assign to_one = 17'h10000 - {1'b0, level_cur};
	assign sq_op  = level_cur[LEVEL_W-1] ? to_one[LEVEL_W-1:0] : level_cur;
	assign sq     = {{LEVEL_W{1'b0}}, sq_op} * {{LEVEL_W{1'b0}}, sq_op};
	assign delta  = sq[2*LEVEL_W-1:LEVEL_W-1];

	always_comb begin
		t_up = {1'b0, level_cur} + delta;
		if (!level_cur[LEVEL_W-1]) begin
			// grow by twice the square, saturating
			t_map = t_up[LEVEL_W] ? LEVEL_MAX : t_up;
		end else if (delta > {1'b0, level_cur}) begin
			t_map = '0;
		end else begin
			// shrink by twice the squared distance to one
			t_map = {1'b0, level_cur} - delta;
		end
	end

	// reseed numerators from the draw, constant multiplies only
	assign low_prod  = {8'b0, draw_s1} * {{DRAW_W{1'b0}}, LOW_SPAN};
	assign high_prod = {8'b0, draw_s1} * {{DRAW_W{1'b0}}, HIGH_SPAN};
	assign low_n     = LOW_BASE + low_prod[DRAW_W+7:DRAW_W];
	assign high_n    = HIGH_BASE + high_prod[DRAW_W+7:DRAW_W];

	// low reseed always lands below the high limit, so only one applies
	always_comb begin
		if (t_map < LOW_LIMIT) begin
			level_new = reseed_level(low_n);
		end else if (t_map > HIGH_LIMIT) begin
			level_new = reseed_level(high_n);
		end else begin
			level_new = t_map[LEVEL_W-1:0];
		end
	end

	// duty = (level * 255) >> 16 as shift and subtract
	assign duty_prod = {level_new, 8'b0} - {8'b0, level_new};
	assign duty_new  = in_range ? duty_prod[LEVEL_W+DUTY_W-1:LEVEL_W] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			channel_s1 <= channel;
			draw_s1    <= random_draw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			channel_q <= channel_s1;
			duty_q    <= duty_new;
		end
	end

	// level store, cleared at reset, written with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				level_q[i] <= '0;
			end
		end else if (advance && valid_s1 && in_range) begin
			level_q[idx] <= level_new;
		end
	end

	assign out_valid   = out_valid_q;
	assign channel_out = channel_q;
	assign duty        = duty_q;

	// input side blocks only when both registers are full and stalled
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("in_ready low with room in the pipeline");

	// a freshly written level is never zero and never above the high limit
	a_level_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && in_range) |=>
		(level_q[$past(idx)] != '0 && {1'b0, level_q[$past(idx)]} <= HIGH_LIMIT))
		else $error("stored level out of map range");

	// a result appears only from an item held in the input register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result without a captured transaction");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the led flicker intermittency-map generator
// ----------------------------------------------------------------------------
// every accepted input transaction is run through a local model of the
// per-channel q0.16 level map, including the low and high reseeds and the
// 8-bit duty scaling. the result is queued, and each output transaction is
// compared with the oldest queued result. stimulus is a short directed pass
// followed by random traffic. both sides idle at random, with a long output
// hold-off and a full drain pause part way through the run.
// ----------------------------------------------------------------------------
module testbench;

	import fcml_pkg::*;

	// map thresholds and reseed constants, q0.16
	localparam int unsigned HALF_LEVEL  = 32768;
	localparam int unsigned FLOOR_LEVEL = 5243;
	localparam int unsigned CEIL_LEVEL  = 65208;
	localparam int unsigned SAT_LEVEL   = 65535;
	localparam int unsigned LO_BASE     = 20;
	localparam int unsigned LO_SPAN     = 60;
	localparam int unsigned HI_BASE     = 128;
	localparam int unsigned HI_SPAN     = 125;
	localparam int unsigned SEED_DIV    = 1023;
	localparam int unsigned PWM_SCALE   = 255;

	localparam int RANDOM_ITEMS = 1850;
	localparam int HOLD_CYCLES  = 64;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 200000;

	// one expected output transaction
	typedef struct packed {
		logic [CH_W-1:0]   ch;
		logic [DUTY_W-1:0] duty;
	} duty_entry_t;

	// keeps its own copy of every channel level and the duties still owed
	class duty_ledger;
		logic [LEVEL_W-1:0] level [NUM_CHANNELS];
		duty_entry_t        duty_due [$];
		int                 fault_count;

		function new();
			foreach (level[i])
				level[i] = '0;
			fault_count = 0;
		endfunction

		// n/1023 in q0.16 with n = base + ((draw * span) >> 16)
		function int unsigned reseed_level(int unsigned draw, int unsigned base,
		                                   int unsigned span);
			int unsigned n;
			n = base + ((draw * span) >> 16);
			return (n << 16) / SEED_DIV;
		endfunction

		function int unsigned next_level(int unsigned lv, int unsigned draw);
			int unsigned t;
			int unsigned d;
			int unsigned dec;
			if (lv < HALF_LEVEL) begin
				t = lv + ((lv * lv) >> 15);
				if (t > SAT_LEVEL)
					t = SAT_LEVEL;
			end else begin
				d   = 65536 - lv;
				dec = (d * d) >> 15;
				t   = (dec > lv) ? 0 : lv - dec;
			end
			if (t < FLOOR_LEVEL)
				t = reseed_level(draw, LO_BASE, LO_SPAN);
			if (t > CEIL_LEVEL)
				t = reseed_level(draw, HI_BASE, HI_SPAN);
			return t & 16'hFFFF;
		endfunction

		// an input transaction was accepted: advance the channel, owe a duty
		function void log_request(logic [CH_W-1:0] ch, logic [DRAW_W-1:0] draw);
			duty_entry_t e;
			int unsigned lv;
			e.ch   = ch;
			e.duty = '0;
			if (ch < NUM_CHANNELS) begin
				lv        = next_level(32'(level[ch]), 32'(draw));
				level[ch] = lv[LEVEL_W-1:0];
				e.duty    = DUTY_W'((lv * PWM_SCALE) >> 16);
			end
			duty_due.push_back(e);
		endfunction

		// an output transaction was accepted: compare with the oldest duty owed
		function void match_duty(logic [CH_W-1:0] ch, logic [DUTY_W-1:0] duty,
		                         realtime t_now);
			duty_entry_t e;
			if (duty_due.size() == 0) begin
				$display("%0t: unexpected result channel_out=%0d duty=%0d", t_now, ch, duty);
				fault_count++;
				return;
			end
			e = duty_due.pop_front();
			if (ch !== e.ch) begin
				$display("%0t: channel_out expected %0d actual %0d", t_now, e.ch, ch);
				fault_count++;
			end
			if (duty !== e.duty) begin
				$display("%0t: duty expected %0d actual %0d", t_now, e.duty, duty);
				fault_count++;
			end
		endfunction

		function int outstanding();
			return duty_due.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [CH_W-1:0]   channel = '0;
	logic [DRAW_W-1:0] random_draw = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [CH_W-1:0]   channel_out;
	logic [DUTY_W-1:0] duty;

	duty_ledger ledger = new();

	// idle_on off gives stretches of back-to-back traffic on both sides
	bit idle_on = 1'b1;
	// one-shot request for a long output hold-off
	bit hold_req = 1'b0;
	int cycle_count = 0;

	flicker_chaos_map_led_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.channel     (channel),
		.random_draw (random_draw),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.channel_out (channel_out),
		.duty        (duty)
	);

	always #1 clk = ~clk;

	// transaction monitor on both channels, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			ledger.log_request(channel, random_draw);
		if (arst_n && out_valid && out_ready)
			ledger.match_duty(channel_out, duty, $realtime);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// output side: random stall per result, or one long hold-off on request
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				stall    = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				stall = idle_on ? $urandom_range(0, 3) : 0;
			end
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// offer one input transaction after a random gap, hold it until taken
	task automatic send_item(logic [CH_W-1:0] ch, logic [DRAW_W-1:0] draw);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		channel     <= ch;
		random_draw <= draw;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop offering, then wait until every owed result has come back
	task automatic wait_all_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (ledger.outstanding() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [CH_W-1:0]   ch;
		logic [DRAW_W-1:0] draw;
		int                kind;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: each channel leaves level zero through the low reseed
		for (int c = 0; c < 8; c++)
			send_item(c[CH_W-1:0], (c % 2 == 0) ? 16'h0000 : 16'hFFFF);
		// draw bit patterns, then a run on one channel starting from a low reseed
		send_item(3'd0, 16'h5555);
		send_item(3'd0, 16'hAAAA);
		send_item(3'd7, 16'hFFFF);
		for (int k = 0; k < 12; k++)
			send_item(3'd5, 16'hFFFF);

		wait_all_results();

		// random traffic
		ch = '0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// alternate idle and back-to-back stretches
			if (i % 300 == 0)
				idle_on = (i % 600 == 0);
			if (i == 700) begin
				// long output hold-off while input keeps coming
				idle_on  = 1'b0;
				hold_req = 1'b1;
			end
			if (i == 1300) begin
				// input pauses until the block has drained
				wait_all_results();
			end
			// bias toward repeats on one channel to walk long map trajectories
			kind = $urandom_range(0, 9);
			if (kind < 5)
				ch = ch;
			else
				ch = CH_W'($urandom_range(0, 7));
			kind = $urandom_range(0, 19);
			if (kind == 0)
				draw = 16'h0000;
			else if (kind == 1)
				draw = 16'hFFFF;
			else
				draw = DRAW_W'($urandom_range(0, 65535));
			send_item(ch, draw);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (ledger.fault_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
